// ----- hw/rtl/fenwick_tree_engine_macros.svh -----
// Assertion macros shared by the Fenwick tree engine RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef FENWICK_TREE_ENGINE_MACROS_SVH
`define FENWICK_TREE_ENGINE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define FTE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define FTE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/fte_pkg.sv -----
// Package for the Fenwick tree engine: widths, codes, sequencer states and
// the control bundle of the shared arithmetic unit. No dependencies.
package fte_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int SEARCH_BITS_DEF = 10;
  localparam int SIZE_W = 11;
  localparam int OP_W   = 3;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
  localparam logic [DATA_W-1:0] MAX_START  = 32'h88CA_6C00; // -2000000000

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 3'd0,
    OP_PSUM   = 3'd1,
    OP_RSUM   = 3'd2,
    OP_MAXU   = 3'd3,
    OP_PMAX   = 3'd4,
    OP_SEARCH = 3'd5
  } fte_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_RD,
    ST_UP_WR,
    ST_DN,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_DONE
  } fte_state_e;

  typedef enum logic [1:0] {
    CMP_RD_LT_VAL,
    CMP_ACC_LT_RD,
    CMP_SUM_LT_VAL
  } fte_cmp_sel_e;

  typedef struct packed {
    logic         use_val;
    logic         sub;
    fte_cmp_sel_e cmp_sel;
  } fte_alu_ctrl_t;

endpackage

// ----- hw/rtl/fte_if.sv -----
// Channel interfaces of the Fenwick tree engine: configuration, request and
// response, each with valid/ready. Depends on fte_pkg.
interface fte_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fte_pkg::SIZE_W-1:0] size_in_use;

  modport source (output valid, output size_in_use, input ready);
  modport sink   (input valid, input size_in_use, output ready);
endinterface

interface fte_req_if;
  logic                       valid;
  logic                       ready;
  logic [fte_pkg::OP_W-1:0]   operation;
  logic [fte_pkg::SIZE_W-1:0] index;
  logic [fte_pkg::SIZE_W-1:0] low_index;
  logic signed [fte_pkg::DATA_W-1:0] value;

  modport source (output valid, output operation, output index, output low_index,
                  output value, input ready);
  modport sink   (input valid, input operation, input index, input low_index,
                  input value, output ready);
endinterface

interface fte_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [fte_pkg::DATA_W-1:0] result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

// ----- hw/rtl/fte_store.sv -----
// Tree word store: one write port, one read port with registered read data.
// Depends on fte_pkg.
module fte_store #(
  parameter int DEPTH  = fte_pkg::MAX_ENTRIES_DEF + 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ADDR_W-1:0]          waddr_i,
  input  logic [fte_pkg::DATA_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [ADDR_W-1:0]          raddr_i,
  output logic [fte_pkg::DATA_W-1:0] rdata_o
);

  logic [fte_pkg::DATA_W-1:0] mem_q [DEPTH];
  logic [fte_pkg::DATA_W-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/fte_alu.sv -----
// Shared arithmetic unit: one 32-bit add/subtract and one signed compare.
// Depends on fte_pkg for the control bundle.
module fte_alu (
  input  fte_pkg::fte_alu_ctrl_t     ctrl_i,
  input  logic [fte_pkg::DATA_W-1:0] rd_i,
  input  logic [fte_pkg::DATA_W-1:0] acc_i,
  input  logic [fte_pkg::DATA_W-1:0] val_i,
  output logic [fte_pkg::DATA_W-1:0] sum_o,
  output logic                       lt_o
);

  logic [fte_pkg::DATA_W-1:0] opnd;
  logic [fte_pkg::DATA_W-1:0] addend;
  logic [fte_pkg::DATA_W-1:0] cmp_a;
  logic [fte_pkg::DATA_W-1:0] cmp_b;

  // Add or subtract the stored word, wrapping at 32 bits
  assign opnd   = ctrl_i.use_val ? val_i : acc_i;
  assign addend = ctrl_i.sub ? ~rd_i : rd_i;
  assign sum_o  = opnd + addend + {{(fte_pkg::DATA_W-1){1'b0}}, ctrl_i.sub};

  // Pick compare operands
  always_comb begin
    case (ctrl_i.cmp_sel)
      fte_pkg::CMP_RD_LT_VAL: begin
        cmp_a = rd_i;
        cmp_b = val_i;
      end
      fte_pkg::CMP_ACC_LT_RD: begin
        cmp_a = acc_i;
        cmp_b = rd_i;
      end
      fte_pkg::CMP_SUM_LT_VAL: begin
        cmp_a = sum_o;
        cmp_b = val_i;
      end
      default: begin
        cmp_a = acc_i;
        cmp_b = rd_i;
      end
    endcase
  end

  assign lt_o = $signed(cmp_a) < $signed(cmp_b);

endmodule

// ----- hw/rtl/fenwick_tree_engine.sv -----
// Fenwick tree engine: binary indexed tree over a one-based word store.
// Channels: cfg_if writes size_in_use (always ready); req_if carries one
// operation (add, prefix sum, range sum, max update, prefix max, lower-bound
// search); rsp_if returns exactly one result per request, zero for updates.
// One request is worked at a time; req_if.ready is high only while idle.
// Steps per request, using the store's read and write ports and the shared ALU:
//   add / max update: a read, then a combine and write-back, per touched position (at most log2(size)+1)
//   prefix sum / prefix max: one store read per set bit of the index
//   range sum: reads for the set bits of index, then for those of low_index-1
//   search: per bit of SEARCH_BITS, a read and a compare when the candidate fits
// The next request is taken, at the earliest, in the cycle after the result is loaded.
// A finished result sits in an output register; the next request may be
// taken while it waits, but completion of that request stalls until the
// register is drained by rsp_if.ready.
// After reset the store is swept to zero, one position a cycle, over
// positions 0 to MAX_ENTRIES; no request is taken meanwhile.
// Reset sets size_in_use to 1024.
// Depends on fte_pkg, fte_if, fte_store, fte_alu and the assertion macros.
`include "fenwick_tree_engine_macros.svh"

module fenwick_tree_engine #(
  parameter int MAX_ENTRIES = fte_pkg::MAX_ENTRIES_DEF,
  parameter int SEARCH_BITS = fte_pkg::SEARCH_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fte_cfg_if.sink     cfg_if,
  fte_req_if.sink     req_if,
  fte_rsp_if.source   rsp_if
);

  localparam int PW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = ((PW > SEARCH_BITS) ? PW : SEARCH_BITS) + 1;
  localparam int BW = $clog2(SEARCH_BITS + 1);
  localparam int CW = (PW > fte_pkg::SIZE_W) ? PW : fte_pkg::SIZE_W;
  localparam int DW = fte_pkg::DATA_W;

  fte_pkg::fte_state_e state_q, state_d;
  fte_pkg::fte_op_e    op_q, op_d;
  logic [fte_pkg::SIZE_W-1:0] size_q;
  logic [PW-1:0] clr_q, clr_d;
  logic [PW-1:0] n_q, n_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [AW-1:0] walk_q, walk_d;
  logic [BW-1:0] rem_q, rem_d;
  logic [DW-1:0] val_q, val_d;
  logic [DW-1:0] acc_q, acc_d;
  logic          pend_q, pend_d;
  logic          phase2_q, phase2_d;
  logic          out_vld_q;
  logic [DW-1:0] out_res_q;

  logic          req_fire;
  logic          out_load;
  logic [CW-1:0] eff_size;
  logic [CW-1:0] hi_clamp;
  logic [CW-1:0] lo_clamp;
  logic          up_ok;
  logic [AW-1:0] lowbit;
  logic [BW-1:0] step_sel;
  logic [AW-1:0] srch_next;
  logic          srch_fits;

  logic          mem_we;
  logic [PW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic          mem_re;
  logic [PW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  fte_pkg::fte_alu_ctrl_t alu_ctrl;
  logic [DW-1:0] alu_sum;
  logic          alu_lt;

  // Handshakes
  assign req_fire      = req_if.valid && req_if.ready;
  assign req_if.ready  = (state_q == fte_pkg::ST_IDLE);
  assign cfg_if.ready  = 1'b1;
  assign rsp_if.valid  = out_vld_q;
  assign rsp_if.result = out_res_q;

  // Effective size and clamped indices at request time
  always_comb begin
    if (size_q == '0) begin
      eff_size = CW'(1);
    end else if (CW'(size_q) > CW'(MAX_ENTRIES)) begin
      eff_size = CW'(MAX_ENTRIES);
    end else begin
      eff_size = CW'(size_q);
    end
    hi_clamp = (CW'(req_if.index) > eff_size) ? eff_size : CW'(req_if.index);
    lo_clamp = (CW'(req_if.low_index) > eff_size) ? eff_size : CW'(req_if.low_index);
  end

  // Walk helpers
  assign lowbit    = walk_q & (~walk_q + AW'(1));
  assign up_ok     = (walk_q != '0) && (walk_q <= AW'(n_q));
  assign step_sel  = (state_q == fte_pkg::ST_SRCH_RD) ? (rem_q - BW'(1)) : rem_q;
  assign srch_next = walk_q | (AW'(1) << step_sel);
  assign srch_fits = srch_next < AW'(n_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fte_pkg::ST_CLEAR: begin
        if (clr_q == PW'(MAX_ENTRIES)) begin
          state_d = fte_pkg::ST_IDLE;
        end
      end
      fte_pkg::ST_IDLE: begin
        if (req_fire) begin
          case (req_if.operation)
            fte_pkg::OP_ADD, fte_pkg::OP_MAXU:                 state_d = fte_pkg::ST_UP_RD;
            fte_pkg::OP_PSUM, fte_pkg::OP_RSUM, fte_pkg::OP_PMAX: state_d = fte_pkg::ST_DN;
            fte_pkg::OP_SEARCH:                                 state_d = fte_pkg::ST_SRCH_RD;
            default:                                            state_d = fte_pkg::ST_DONE;
          endcase
        end
      end
      fte_pkg::ST_UP_RD: begin
        state_d = up_ok ? fte_pkg::ST_UP_WR : fte_pkg::ST_DONE;
      end
      fte_pkg::ST_UP_WR: begin
        state_d = fte_pkg::ST_UP_RD;
      end
      fte_pkg::ST_DN: begin
        if ((walk_q == '0) && !pend_q &&
            !((op_q == fte_pkg::OP_RSUM) && !phase2_q)) begin
          state_d = fte_pkg::ST_DONE;
        end
      end
      fte_pkg::ST_SRCH_RD: begin
        if (rem_q == '0) begin
          state_d = fte_pkg::ST_DONE;
        end else if (srch_fits) begin
          state_d = fte_pkg::ST_SRCH_CHK;
        end
      end
      fte_pkg::ST_SRCH_CHK: begin
        state_d = fte_pkg::ST_SRCH_RD;
      end
      fte_pkg::ST_DONE: begin
        if (!out_vld_q || rsp_if.ready) begin
          state_d = fte_pkg::ST_IDLE;
        end
      end
      default: state_d = fte_pkg::ST_IDLE;
    endcase
  end

  // Datapath and store control
  always_comb begin
    op_d     = op_q;
    n_d      = n_q;
    lo_d     = lo_q;
    val_d    = val_q;
    walk_d   = walk_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    pend_d   = pend_q;
    phase2_d = phase2_q;
    clr_d    = clr_q;
    out_load = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = walk_q[PW-1:0];
    mem_wdata = alu_sum;
    mem_re    = 1'b0;
    mem_raddr = walk_q[PW-1:0];
    alu_ctrl.use_val = 1'b0;
    alu_ctrl.sub     = 1'b0;
    alu_ctrl.cmp_sel = fte_pkg::CMP_ACC_LT_RD;

    case (state_q)
      // Sweep the store to zero
      fte_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + PW'(1);
      end
      // Latch the transaction
      fte_pkg::ST_IDLE: begin
        if (req_fire) begin
          op_d     = fte_pkg::fte_op_e'(req_if.operation);
          n_d      = PW'(eff_size);
          lo_d     = PW'(lo_clamp);
          val_d    = req_if.value;
          walk_d   = (req_if.operation == fte_pkg::OP_SEARCH) ? '0 : AW'(hi_clamp);
          acc_d    = (req_if.operation == fte_pkg::OP_PMAX) ? fte_pkg::MAX_START : '0;
          rem_d    = BW'(SEARCH_BITS);
          pend_d   = 1'b0;
          phase2_d = 1'b0;
        end
      end
      // Upward walk: read the position
      fte_pkg::ST_UP_RD: begin
        mem_re = up_ok;
      end
      // Upward walk: combine and write back, advance
      fte_pkg::ST_UP_WR: begin
        alu_ctrl.use_val = 1'b1;
        alu_ctrl.cmp_sel = fte_pkg::CMP_RD_LT_VAL;
        mem_we = 1'b1;
        if (op_q == fte_pkg::OP_ADD) begin
          mem_wdata = alu_sum;
        end else begin
          mem_wdata = alu_lt ? val_q : mem_rdata;
        end
        walk_d = walk_q + lowbit;
      end
      // Downward walk: read one position a cycle, fold the returning word
      fte_pkg::ST_DN: begin
        alu_ctrl.sub     = phase2_q;
        alu_ctrl.cmp_sel = fte_pkg::CMP_ACC_LT_RD;
        if (pend_q) begin
          if (op_q == fte_pkg::OP_PMAX) begin
            acc_d = alu_lt ? mem_rdata : acc_q;
          end else begin
            acc_d = alu_sum;
          end
        end
        if (walk_q != '0) begin
          mem_re = 1'b1;
          walk_d = walk_q - lowbit;
          pend_d = 1'b1;
        end else begin
          pend_d = 1'b0;
          if (!pend_q && (op_q == fte_pkg::OP_RSUM) && !phase2_q) begin
            phase2_d = 1'b1;
            walk_d   = (lo_q != '0) ? (AW'(lo_q) - AW'(1)) : '0;
          end
        end
      end
      // Search: propose the next step
      fte_pkg::ST_SRCH_RD: begin
        if (rem_q == '0) begin
          acc_d = DW'(walk_q) + DW'(1);
        end else begin
          rem_d = rem_q - BW'(1);
          if (srch_fits) begin
            mem_re    = 1'b1;
            mem_raddr = srch_next[PW-1:0];
          end
        end
      end
      // Search: take the step if the candidate sum is below target
      fte_pkg::ST_SRCH_CHK: begin
        alu_ctrl.cmp_sel = fte_pkg::CMP_SUM_LT_VAL;
        if (alu_lt) begin
          walk_d = srch_next;
          acc_d  = alu_sum;
        end
      end
      // Hand the result to the output register
      fte_pkg::ST_DONE: begin
        out_load = !out_vld_q || rsp_if.ready;
      end
      default: begin
        clr_d = clr_q;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= fte_pkg::ST_CLEAR;
      clr_q     <= '0;
      size_q    <= fte_pkg::SIZE_RESET;
      pend_q    <= 1'b0;
      phase2_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      pend_q   <= pend_d;
      phase2_q <= phase2_d;
      if (cfg_if.valid && cfg_if.ready) begin
        size_q <= cfg_if.size_in_use;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_if.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    n_q    <= n_d;
    lo_q   <= lo_d;
    val_q  <= val_d;
    walk_q <= walk_d;
    acc_q  <= acc_d;
    rem_q  <= rem_d;
    if (out_load) begin
      out_res_q <= acc_q;
    end
  end

  fte_store #(
    .DEPTH  (MAX_ENTRIES + 1),
    .ADDR_W (PW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  fte_alu u_alu (
    .ctrl_i (alu_ctrl),
    .rd_i   (mem_rdata),
    .acc_i  (acc_q),
    .val_i  (val_q),
    .sum_o  (alu_sum),
    .lt_o   (alu_lt)
  );

  // Assertions
  `FTE_ASSERT_IMP(a_rd_range, mem_re && (state_q != fte_pkg::ST_CLEAR),
    (mem_raddr != '0) && (mem_raddr <= n_q), "store read outside active positions")
  `FTE_ASSERT_IMP(a_wr_range, mem_we && (state_q != fte_pkg::ST_CLEAR),
    (mem_waddr != '0) && (mem_waddr <= n_q), "store write outside active positions")
  `FTE_ASSERT_IMP(a_srch_pos, state_q == fte_pkg::ST_SRCH_RD,
    walk_q < AW'(n_q), "search position reached size")
  `FTE_ASSERT_NXT(a_rsp_load, out_load,
    rsp_if.valid && (rsp_if.result == $past(acc_q)), "result not loaded")

endmodule

// ----- sim/fenwick_tree_engine_checker.sv -----
// Checker for the Fenwick tree engine: watches the size, request and response
// channels, keeps its own copy of the tree, and compares each result in order.
// Depends on fte_pkg and the channel interfaces in fte_if.
module fenwick_tree_engine_checker (
  input  logic clk_i,
  input  logic rst_ni,
  fte_cfg_if   cfg_mon,
  fte_req_if   req_mon,
  fte_rsp_if   rsp_mon,
  output int   fail_count,
  output int   pending_count
);
  import fte_pkg::*;

  localparam int ENTRIES   = MAX_ENTRIES_DEF;
  localparam int WALK_BITS = SEARCH_BITS_DEF;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] index;
    logic [DATA_W-1:0] result;
  } answer_t;

  logic [DATA_W-1:0] tree_words [1:ENTRIES];
  logic [SIZE_W-1:0] size_reg;
  answer_t           answers_due [$];

  // Print one line per mismatch and count it
  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic int active_size();
    if (size_reg == '0) return 1;
    if (size_reg > ENTRIES) return ENTRIES;
    return size_reg;
  endfunction

  function automatic int lowest_bit(int x);
    return x & -x;
  endfunction

  function automatic logic [DATA_W-1:0] prefix_total(int pos);
    logic [DATA_W-1:0] acc;
    acc = '0;
    while (pos > 0) begin
      acc += tree_words[pos];
      pos -= lowest_bit(pos);
    end
    return acc;
  endfunction

  function automatic logic signed [DATA_W-1:0] prefix_peak(int pos);
    logic signed [DATA_W-1:0] best;
    best = MAX_START;
    while (pos > 0) begin
      if ($signed(tree_words[pos]) > best) best = tree_words[pos];
      pos -= lowest_bit(pos);
    end
    return best;
  endfunction

  // Walk upward through every node that covers pos
  function automatic void add_at(int pos, logic [DATA_W-1:0] delta, int n);
    while (pos > 0 && pos <= n) begin
      tree_words[pos] += delta;
      pos += lowest_bit(pos);
    end
  endfunction

  function automatic void raise_at(int pos, logic signed [DATA_W-1:0] cand, int n);
    while (pos > 0 && pos <= n) begin
      if ($signed(tree_words[pos]) < cand) tree_words[pos] = cand;
      pos += lowest_bit(pos);
    end
  endfunction

  // Descend by powers of two, never stepping onto a node at or above n
  function automatic logic [DATA_W-1:0] first_reaching(logic signed [DATA_W-1:0] goal, int n);
    int                pos;
    int                probe;
    logic [DATA_W-1:0] acc;
    pos = 0;
    acc = '0;
    for (int b = WALK_BITS - 1; b >= 0; b--) begin
      probe = pos + (1 << b);
      if (probe < n) begin
        if ($signed(tree_words[probe] + acc) < goal) begin
          pos = probe;
          acc += tree_words[probe];
        end
      end
    end
    return DATA_W'(pos + 1);
  endfunction

  // Apply one request to the shadow tree and return its result
  function automatic logic [DATA_W-1:0] predict_result(input logic [OP_W-1:0] op,
                                                       input logic [SIZE_W-1:0] hi_raw,
                                                       input logic [SIZE_W-1:0] lo_raw,
                                                       input logic [DATA_W-1:0] val);
    int                n;
    int                hi;
    int                lo;
    logic [DATA_W-1:0] below;
    n  = active_size();
    hi = (hi_raw > n) ? n : hi_raw;
    lo = (lo_raw > n) ? n : lo_raw;
    case (op)
      OP_ADD: begin
        add_at(hi, val, n);
        return '0;
      end
      OP_PSUM: return prefix_total(hi);
      OP_RSUM: begin
        below = (lo > 0) ? prefix_total(lo - 1) : '0;
        return prefix_total(hi) - below;
      end
      OP_MAXU: begin
        raise_at(hi, val, n);
        return '0;
      end
      OP_PMAX:   return prefix_peak(hi);
      OP_SEARCH: return first_reaching(val, n);
      default:   return '0;
    endcase
  endfunction

  // Check the response first, then queue new requests, then track size writes
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t due;
    if (!rst_ni) begin
      for (int i = 1; i <= ENTRIES; i++) tree_words[i] = '0;
      size_reg = SIZE_RESET;
      answers_due.delete();
      fail_count = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (answers_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with no request outstanding",
                                    $signed(rsp_mon.result)));
        end else begin
          due = answers_due.pop_front();
          if (rsp_mon.result !== due.result) begin
            report_mismatch($sformatf("op %0d index %0d: result %0d, expected %0d",
                                      due.op, due.index, $signed(rsp_mon.result),
                                      $signed(due.result)));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        due.op     = req_mon.operation;
        due.index  = req_mon.index;
        due.result = predict_result(req_mon.operation, req_mon.index, req_mon.low_index,
                                    req_mon.value);
        answers_due.push_back(due);
      end
      if (cfg_mon.valid && cfg_mon.ready) size_reg = cfg_mon.size_in_use;
    end
    pending_count = answers_due.size();
  end

endmodule

// ----- sim/fenwick_tree_engine_test.sv -----
// Testbench top for the Fenwick tree engine: clock, reset, size writes,
// request stimulus and response back-pressure. Depends on fte_pkg, fte_if,
// the engine RTL and fenwick_tree_engine_checker.
module fenwick_tree_engine_test;
  import fte_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 135;
  localparam int HOLD_AFTER   = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int CALM_PHASE   = 3;
  localparam int INDEX_TOP    = (1 << SIZE_W) - 1;

  // Operation codes the engine leaves unused
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   cycle_count = 0;
  int   items_sent  = 0;
  int   live_size   = MAX_ENTRIES_DEF;
  logic calm        = 1'b0;
  logic stall_hold  = 1'b0;

  logic [SIZE_W-1:0] phase_sizes [PHASES] = '{11'd1, 11'd0, 11'd2047, 11'd1025, 11'd2,
                                              11'd3, 11'd1024, 11'd17, 11'd512, 11'd1};

  fte_cfg_if cfg_ch ();
  fte_req_if req_ch ();
  fte_rsp_if rsp_ch ();

  fenwick_tree_engine u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_if (cfg_ch),
    .req_if (req_ch),
    .rsp_if (rsp_ch)
  );

  fenwick_tree_engine_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_mon       (cfg_ch),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response back-pressure: random stalls, none while calm, ready held low throughout a hold
  always @(posedge clk_i) begin
    rsp_ch.ready <= !stall_hold && (calm || $urandom_range(99) >= 34);
  end

  // Hold off the response side for a long stretch once traffic is flowing
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk_i);
    stall_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    stall_hold <= 1'b0;
  end

  // Offer one request, with an optional gap first; return at its transaction edge
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [SIZE_W-1:0] hi,
                               input logic [SIZE_W-1:0] lo, input logic [DATA_W-1:0] val);
    if (!calm && $urandom_range(99) < 34) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 40 : 5)) @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.index     <= hi;
    req_ch.low_index <= lo;
    req_ch.value     <= val;
    do @(posedge clk_i); while (!req_ch.ready);
    items_sent++;
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] size_w);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.size_in_use <= size_w;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    live_size = (size_w == '0) ? 1 : ((size_w > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : size_w);
  endtask

  // Wait until every result has come back, sampled away from the clock edge
  task automatic drain_results();
    do @(negedge clk_i); while (pending_count != 0);
  endtask

  // Mostly in range, with zero, the top and clamped values mixed in
  function automatic logic [SIZE_W-1:0] pick_index(int n);
    int r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 14) return SIZE_W'($urandom_range(n, INDEX_TOP));
    if (r < 20) return SIZE_W'(n);
    return SIZE_W'($urandom_range(1, n));
  endfunction

  // Small deltas keep prefix sums ordered enough for searches to land inside
  function automatic logic [DATA_W-1:0] pick_value(logic [OP_W-1:0] op);
    int r;
    r = $urandom_range(99);
    case (op)
      OP_ADD: begin
        if (r < 80) return $urandom_range(50);
        if (r < 97) return 32'd0 - $urandom_range(1, 50);
        return $urandom;
      end
      OP_MAXU: begin
        if (r < 50) return $urandom;
        return $urandom_range(200) - 100;
      end
      OP_SEARCH: begin
        if (r < 70) return $urandom_range(4000);
        if (r < 85) return $urandom;
        return 32'd0 - $urandom_range(100);
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [OP_W-1:0]   op;
    logic [SIZE_W-1:0] size_w;

    rst_ni             <= 1'b0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.size_in_use <= SIZE_RESET;
    req_ch.valid       <= 1'b0;
    req_ch.operation   <= OP_ADD;
    req_ch.index       <= '0;
    req_ch.low_index   <= '0;
    req_ch.value       <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Let the clearing sweep finish before the first write
    do @(posedge clk_i); while (!req_ch.ready);
    write_size(SIZE_RESET);

    // Directed: field extremes, every operation, clamping and wrap cases
    issue_request(OP_ADD,    11'd1,    11'd1,    32'h7FFF_FFFF);
    issue_request(OP_ADD,    11'd1024, 11'd1,    32'h8000_0000);
    issue_request(OP_ADD,    11'd0,    11'd1,    32'd5);
    issue_request(OP_ADD,    11'd2047, 11'd2047, 32'hFFFF_FFFF);
    issue_request(OP_ADD,    11'd700,  11'd1,    32'd123);
    issue_request(OP_PSUM,   11'd1024, 11'd1,    32'd0);
    issue_request(OP_PSUM,   11'd0,    11'd1,    32'hFFFF_FFFF);
    issue_request(OP_PSUM,   11'd1,    11'd1,    32'd0);
    issue_request(OP_PSUM,   11'd2047, 11'd1,    32'd0);
    issue_request(OP_RSUM,   11'd1024, 11'd1,    32'd0);
    issue_request(OP_RSUM,   11'd3,    11'd1000, 32'd0);
    issue_request(OP_RSUM,   11'd800,  11'd0,    32'd0);
    issue_request(OP_RSUM,   11'd2047, 11'd2047, 32'd0);
    issue_request(OP_MAXU,   11'd5,    11'd1,    32'h7FFF_FFFF);
    issue_request(OP_MAXU,   11'd7,    11'd1,    32'h8000_0000);
    issue_request(OP_MAXU,   11'd0,    11'd1,    32'd9);
    issue_request(OP_PMAX,   11'd0,    11'd1,    32'd0);
    issue_request(OP_PMAX,   11'd1024, 11'd1,    32'd0);
    issue_request(OP_PMAX,   11'd6,    11'd1,    32'd0);
    issue_request(OP_SEARCH, 11'd0,    11'd1,    32'h8000_0000);
    issue_request(OP_SEARCH, 11'd0,    11'd1,    32'h7FFF_FFFF);
    issue_request(OP_SEARCH, 11'd0,    11'd1,    32'd0);
    issue_request(OP_SEARCH, 11'd0,    11'd1,    32'd200);
    issue_request(OP_SPARE_LO, 11'd3,  11'd1,    32'd77);
    issue_request(OP_SPARE_HI, 11'd2047, 11'd2047, 32'hFFFF_FFFF);
    req_ch.valid <= 1'b0;

    // Random phases, each under its own size setting
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      repeat (4) @(posedge clk_i);
      size_w = (p == PHASES - 1) ? SIZE_W'($urandom_range(1, MAX_ENTRIES_DEF)) : phase_sizes[p];
      write_size(size_w);
      calm = (p == CALM_PHASE);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = ($urandom_range(99) < 4) ? OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI))
                                      : OP_W'($urandom_range(OP_ADD, OP_SEARCH));
        issue_request(op, pick_index(live_size), pick_index(live_size), pick_value(op));
      end
      req_ch.valid <= 1'b0;
      calm = 1'b0;
    end

    // Drain, then leave room for any stray result
    drain_results();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/fte_pkg.sv
hw/rtl/fte_if.sv
hw/rtl/fte_store.sv
hw/rtl/fte_alu.sv
hw/rtl/fenwick_tree_engine.sv
sim/fenwick_tree_engine_checker.sv
sim/fenwick_tree_engine_test.sv
